// File: rtl/hsec_pkg.sv
// Shared types, widths and bit placement functions for the Hamming SEC encoder/decoder.
package hsec_pkg;

    // Field widths
    localparam int CW_W          = 64;
    localparam int DATA_W        = 57;
    localparam int SYN_W         = 7;
    localparam int KLEN_W        = 6;
    localparam int NLEN_W        = 7;
    localparam int RLEN_W        = 3;
    localparam int DATA_BITS_MAX = 57;

    // Default for the longest codeword the block may build
    localparam int MAX_CODEWORD_BITS_DEF = 64;

    typedef enum logic
    {
        OP_ENCODE = 1'b0,
        OP_DECODE = 1'b1
    } opcode_t;

    typedef enum logic [1:0]
    {
        ST_OK           = 2'd0,
        ST_CORRECTED    = 2'd1,
        ST_OUT_OF_RANGE = 2'd2
    } status_t;

    // True for the check-bit positions (1, 2, 4, ...)
    function automatic logic is_pow2(int p);
        return (p != 0) && ((p & (p - 1)) == 0);
    endfunction

    // Least r >= 1 with 2^r >= k + r + 1
    function automatic logic [RLEN_W-1:0] check_count(logic [KLEN_W-1:0] k);
        logic [RLEN_W-1:0] r;
        r = RLEN_W'(SYN_W);
        for (int i = SYN_W; i >= 1; i--)
        begin
            if ((8'd1 << i) >= (8'(k) + 8'(i) + 8'd1))
                r = RLEN_W'(i);
        end
        return r;
    endfunction

    // Longest data length whose codeword fits in max_cw bits (elaboration only)
    function automatic int max_data_len(int max_cw);
        int kmax;
        kmax = 1;
        for (int k = 1; k <= DATA_BITS_MAX; k++)
        begin
            if (k + int'(check_count(KLEN_W'(k))) <= max_cw)
                kmax = k;
        end
        return kmax;
    endfunction

    // Place data bits at the non-power positions in ascending order
    function automatic logic [CW_W-1:0] scatter(logic [DATA_W-1:0] d);
        logic [CW_W-1:0] cw;
        int              dpos;
        cw   = '0;
        dpos = 0;
        for (int p = 1; p <= CW_W; p++)
        begin
            if (!is_pow2(p) && dpos < DATA_W)
            begin
                cw[p-1] = d[dpos];
                dpos++;
            end
        end
        return cw;
    endfunction

    // Pull the data bits back out of the non-power positions
    function automatic logic [DATA_W-1:0] gather(logic [CW_W-1:0] cw);
        logic [DATA_W-1:0] d;
        int                dpos;
        d    = '0;
        dpos = 0;
        for (int p = 1; p <= CW_W; p++)
        begin
            if (!is_pow2(p) && dpos < DATA_W)
            begin
                d[dpos] = cw[p-1];
                dpos++;
            end
        end
        return d;
    endfunction

    // XOR of the indices of all set positions; bit i is the parity of group 2^i
    function automatic logic [SYN_W-1:0] parity_groups(logic [CW_W-1:0] cw);
        logic [SYN_W-1:0] s;
        s = '0;
        for (int p = 1; p <= CW_W; p++)
        begin
            for (int i = 0; i < SYN_W; i++)
            begin
                if (((p >> i) & 1) == 1)
                    s[i] = s[i] ^ cw[p-1];
            end
        end
        return s;
    endfunction

    // Ones in the low n bits of a codeword
    function automatic logic [CW_W-1:0] cw_mask(logic [NLEN_W-1:0] n);
        logic [CW_W-1:0] m;
        for (int p = 0; p < CW_W; p++)
            m[p] = (NLEN_W'(p) < n);
        return m;
    endfunction

    // Ones in the low k bits of a data word
    function automatic logic [DATA_W-1:0] data_mask(logic [KLEN_W-1:0] k);
        logic [DATA_W-1:0] m;
        for (int p = 0; p < DATA_W; p++)
            m[p] = (KLEN_W'(p) < k);
        return m;
    endfunction

endpackage

// File: rtl/hsec_if.sv
// Valid/ready channel interfaces for the Hamming SEC block's input and result items.
interface hsec_in_if;
    logic                       valid;
    logic                       ready;
    logic                       opcode;
    logic [hsec_pkg::CW_W-1:0]  word_in;

    modport source (output valid, output opcode, output word_in, input ready);
    modport sink   (input valid, input opcode, input word_in, output ready);
endinterface

interface hsec_out_if;
    logic                        valid;
    logic                        ready;
    logic [hsec_pkg::CW_W-1:0]   codeword_out;
    logic [hsec_pkg::DATA_W-1:0] data_out;
    logic [hsec_pkg::SYN_W-1:0]  syndrome;
    logic [1:0]                  status;

    modport source (output valid, output codeword_out, output data_out,
                    output syndrome, output status, input ready);
    modport sink   (input valid, input codeword_out, input data_out,
                    input syndrome, input status, output ready);
endinterface

// File: rtl/hamming_sec_encode_decode_unit.sv
// Hamming SEC encoder/decoder top level: input register, coding logic, result register.
// Path from item acceptance to result valid: input register, then result register.
// Throughput: one item per cycle unless the result sink stalls; set by the single
// pass of parity trees between the two registers. Input ready follows the result
// register draining, so no bubbles. Reset (rst_n low, asynchronous): both stages
// empty, data length back to 57 (shortened if the codeword limit demands).
module hamming_sec_encode_decode_unit #(
    parameter int MAX_CODEWORD_BITS = hsec_pkg::MAX_CODEWORD_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    hsec_in_if.sink                      in_ch,
    hsec_out_if.source                   out_ch,
    input  logic                         cfg_wr_en,
    input  logic [hsec_pkg::KLEN_W-1:0]  cfg_wr_data
);

    // Geometry limits worked out at elaboration
    localparam int KMAX    = hsec_pkg::max_data_len(MAX_CODEWORD_BITS);
    localparam int K_RESET = (hsec_pkg::DATA_BITS_MAX < KMAX) ? hsec_pkg::DATA_BITS_MAX : KMAX;
    localparam int N_RESET = K_RESET + int'(hsec_pkg::check_count(hsec_pkg::KLEN_W'(K_RESET)));

    // Effective geometry, updated on configuration writes
    logic [hsec_pkg::KLEN_W-1:0] k_reg, k_next;
    logic [hsec_pkg::NLEN_W-1:0] n_reg, n_next;

    // Input stage
    logic                        s1_valid_reg;
    hsec_pkg::opcode_t           s1_opcode_reg;
    logic [hsec_pkg::CW_W-1:0]   s1_word_reg;

    // Result stage
    logic                        out_valid_reg;
    logic [hsec_pkg::CW_W-1:0]   codeword_reg, codeword_next;
    logic [hsec_pkg::DATA_W-1:0] data_reg, data_next;
    logic [hsec_pkg::SYN_W-1:0]  syndrome_reg, syndrome_next;
    hsec_pkg::status_t           status_reg, status_next;

    logic out_adv;

    // Clamp the requested length and shorten it to fit the codeword limit
    always_comb
    begin
        priority if (cfg_wr_data == '0)
            k_next = hsec_pkg::KLEN_W'(1);
        else if (cfg_wr_data > hsec_pkg::KLEN_W'(K_RESET))
            k_next = hsec_pkg::KLEN_W'(K_RESET);
        else
            k_next = cfg_wr_data;
        n_next = hsec_pkg::NLEN_W'(k_next) + hsec_pkg::NLEN_W'(hsec_pkg::check_count(k_next));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg <= hsec_pkg::KLEN_W'(K_RESET);
            n_reg <= hsec_pkg::NLEN_W'(N_RESET);
        end
        else if (cfg_wr_en)
        begin
            k_reg <= k_next;
            n_reg <= n_next;
        end
    end

    // Handshake: each stage moves when the one after it has room
    assign out_adv     = !out_valid_reg || out_ch.ready;
    assign in_ch.ready = !s1_valid_reg || out_adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ch.ready)
                s1_valid_reg <= in_ch.valid;
            if (out_adv)
                out_valid_reg <= s1_valid_reg;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
        begin
            s1_opcode_reg <= hsec_pkg::opcode_t'(in_ch.opcode);
            s1_word_reg   <= in_ch.word_in;
        end
        if (s1_valid_reg && out_adv)
        begin
            codeword_reg <= codeword_next;
            data_reg     <= data_next;
            syndrome_reg <= syndrome_next;
            status_reg   <= status_next;
        end
    end

    // Encode / check-and-correct logic
    logic [hsec_pkg::CW_W-1:0]  nmask, enc_placed, enc_cw, dec_rx, dec_cw;
    logic [hsec_pkg::SYN_W-1:0] enc_chk, dec_syn;
    logic                       dec_flip;

    always_comb
    begin
        nmask = hsec_pkg::cw_mask(n_reg);

        // Encode: place data, then fill each check position with its group parity
        enc_placed = hsec_pkg::scatter(s1_word_reg[hsec_pkg::DATA_W-1:0] &
                                       hsec_pkg::data_mask(k_reg));
        enc_chk    = hsec_pkg::parity_groups(enc_placed);
        enc_cw     = enc_placed;
        for (int i = 0; i < hsec_pkg::SYN_W; i++)
            enc_cw[(1 << i) - 1] = enc_chk[i];
        enc_cw     = enc_cw & nmask;

        // Decode: syndrome over the in-range bits, flip the named bit if inside
        dec_rx   = s1_word_reg & nmask;
        dec_syn  = hsec_pkg::parity_groups(dec_rx);
        dec_flip = (dec_syn != '0) && (dec_syn <= n_reg);
        for (int p = 1; p <= hsec_pkg::CW_W; p++)
            dec_cw[p-1] = dec_rx[p-1] ^ (dec_flip && (dec_syn == hsec_pkg::SYN_W'(p)));

        unique case (s1_opcode_reg)
            hsec_pkg::OP_ENCODE:
            begin
                codeword_next = enc_cw;
                data_next     = '0;
                syndrome_next = '0;
                status_next   = hsec_pkg::ST_OK;
            end
            hsec_pkg::OP_DECODE:
            begin
                codeword_next = dec_cw;
                data_next     = hsec_pkg::gather(dec_cw);
                syndrome_next = dec_syn;
                priority if (dec_syn == '0)
                    status_next = hsec_pkg::ST_OK;
                else if (dec_flip)
                    status_next = hsec_pkg::ST_CORRECTED;
                else
                    status_next = hsec_pkg::ST_OUT_OF_RANGE;
            end
            default:
            begin
                codeword_next = '0;
                data_next     = '0;
                syndrome_next = '0;
                status_next   = hsec_pkg::ST_OK;
            end
        endcase
    end

    // Result channel
    assign out_ch.valid        = out_valid_reg;
    assign out_ch.codeword_out = codeword_reg;
    assign out_ch.data_out     = data_reg;
    assign out_ch.syndrome     = syndrome_reg;
    assign out_ch.status       = status_reg;

endmodule

// File: rtl/hsec_checker.sv
// Port-level checks for the Hamming SEC block, bound to its top level.
module hsec_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_ready,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic [hsec_pkg::SYN_W-1:0]  syndrome,
    input logic [1:0]                  status,
    input logic [hsec_pkg::CW_W-1:0]   codeword_out
);

    // A stalled result item holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(codeword_out))
        else $error("result item changed while stalled");

    // An error status always comes with a non-zero syndrome
    a_status_syn: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != 2'(hsec_pkg::ST_OK)) |-> (syndrome != '0))
        else $error("error status with zero syndrome");

    // A zero syndrome means nothing was corrected or flagged
    a_syn_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (syndrome == '0) |-> (status == 2'(hsec_pkg::ST_OK)))
        else $error("zero syndrome with error status");

    // An accepted item moves through the input register to the result register when the sink keeps up
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) ##1 out_ready |=> out_valid)
        else $error("item did not reach the output in two cycles");

endmodule

bind hamming_sec_encode_decode_unit hsec_checker u_hsec_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_ch.valid),
    .in_ready     (in_ch.ready),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .syndrome     (out_ch.syndrome),
    .status       (out_ch.status),
    .codeword_out (out_ch.codeword_out)
);

// File: test/hamming_sec_encode_decode_unit_tb.sv
// Self-checking testbench for the Hamming SEC encode/decode unit: directed and random items.
`timescale 1ns / 100ps

module hamming_sec_encode_decode_unit_tb;

    localparam int MAX_CW       = hsec_pkg::MAX_CODEWORD_BITS_DEF;
    localparam int RANDOM_PHASES = 12;
    localparam int PHASE_ITEMS  = 120;
    localparam int LONG_HOLD    = 300;
    localparam int REPORT_LIMIT = 10;

    typedef struct {
        hsec_pkg::opcode_t          op;
        logic [hsec_pkg::CW_W-1:0]  word;
    } code_item_t;

    typedef struct {
        logic [hsec_pkg::CW_W-1:0]   codeword;
        logic [hsec_pkg::DATA_W-1:0] data;
        logic [hsec_pkg::SYN_W-1:0]  syndrome;
        hsec_pkg::status_t           status;
    } code_result_t;

    logic clk;
    logic rst_n;
    logic cfg_wr_en;
    logic [hsec_pkg::KLEN_W-1:0] cfg_wr_data;

    hsec_in_if  in_ch ();
    hsec_out_if out_ch ();

    hamming_sec_encode_decode_unit u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_ch       (in_ch),
        .out_ch      (out_ch),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    // Testbench state
    code_item_t   pending_items [$];
    code_result_t expected_results [$];
    logic [hsec_pkg::KLEN_W-1:0] len_setting = 6'd57;
    logic in_taken  = 1'b0;
    logic send_hold = 1'b0;
    logic recv_hold = 1'b0;
    int   send_idle_pct  = 0;
    int   recv_stall_pct = 0;
    int   fail_count     = 0;
    int   encode_count   = 0;
    int   decode_count   = 0;
    int   corrected_count = 0;
    int   beyond_count   = 0;
    int   length_writes  = 0;
    event hold_off_ev;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Effective data length k and check-bit count r for a register value
    function automatic void code_geometry(input logic [hsec_pkg::KLEN_W-1:0] len,
                                          output int k, output int r);
        k = int'(len);
        if (k < 1) k = 1;
        if (k > hsec_pkg::DATA_BITS_MAX) k = hsec_pkg::DATA_BITS_MAX;
        r = 1;
        while ((1 << r) < k + r + 1) r++;
        while (k + r > MAX_CW && k > 1)
        begin
            k--;
            r = 1;
            while ((1 << r) < k + r + 1) r++;
        end
    endfunction

    // Expected result of one item under a given length setting
    function automatic code_result_t hamming_predict(logic [hsec_pkg::KLEN_W-1:0] len,
                                                     hsec_pkg::opcode_t op,
                                                     logic [hsec_pkg::CW_W-1:0] word);
        code_result_t res;
        int k, r, n, dpos, syn;
        logic par;
        logic [hsec_pkg::CW_W-1:0] cw;
        logic [hsec_pkg::DATA_W-1:0] data;
        code_geometry(len, k, r);
        n    = k + r;
        dpos = 0;
        syn  = 0;
        cw   = '0;
        data = '0;
        res.data     = '0;
        res.syndrome = '0;
        res.status   = hsec_pkg::ST_OK;
        if (op == hsec_pkg::OP_ENCODE)
        begin
            // data into the non-power positions
            for (int p = 1; p <= n; p++)
            begin
                if ((p & (p - 1)) != 0)
                begin
                    cw[p-1] = word[dpos];
                    dpos++;
                end
            end
            // each check bit evens out its group
            for (int i = 0; i < r; i++)
            begin
                par = 1'b0;
                for (int p = 1; p <= n; p++)
                begin
                    if (((p >> i) & 1) == 1 && p != (1 << i))
                        par = par ^ cw[p-1];
                end
                cw[(1 << i) - 1] = par;
            end
            res.codeword = cw;
            return res;
        end
        // decode: syndrome over the low n bits only
        for (int p = 1; p <= n; p++)
        begin
            cw[p-1] = word[p-1];
            if (word[p-1])
                syn = syn ^ p;
        end
        if (syn != 0)
        begin
            if (syn <= n)
            begin
                cw[syn-1]  = ~cw[syn-1];
                res.status = hsec_pkg::ST_CORRECTED;
            end
            else
                res.status = hsec_pkg::ST_OUT_OF_RANGE;
        end
        for (int p = 1; p <= n; p++)
        begin
            if ((p & (p - 1)) != 0)
            begin
                data[dpos] = cw[p-1];
                dpos++;
            end
        end
        res.codeword = cw;
        res.data     = data;
        res.syndrome = hsec_pkg::SYN_W'(syn);
        return res;
    endfunction

    // Clean codeword for some data under the current length
    function automatic logic [hsec_pkg::CW_W-1:0] valid_codeword(logic [hsec_pkg::CW_W-1:0] d);
        code_result_t res;
        res = hamming_predict(len_setting, hsec_pkg::OP_ENCODE, d);
        return res.codeword;
    endfunction

    task automatic add_item(hsec_pkg::opcode_t op, logic [hsec_pkg::CW_W-1:0] word);
        code_item_t it;
        it.op   = op;
        it.word = word;
        pending_items.push_back(it);
    endtask

    // Encode items, and decode items of mostly well-formed codewords with single flips, stray high bits and noise
    task automatic add_random_item();
        int k, r, n, sel;
        logic [hsec_pkg::CW_W-1:0] word, junk, low_bits;
        code_geometry(len_setting, k, r);
        n        = k + r;
        low_bits = (n >= hsec_pkg::CW_W) ? '1 : ((64'd1 << n) - 64'd1);
        junk     = ($urandom_range(1) == 1) ? ({$urandom, $urandom} & ~low_bits) : '0;
        word     = valid_codeword({$urandom, $urandom});
        sel      = $urandom_range(99);
        if (sel < 25)
            add_item(hsec_pkg::OP_ENCODE, {$urandom, $urandom});
        else if (sel < 50)
            add_item(hsec_pkg::OP_DECODE, word | junk);
        else if (sel < 85)
            add_item(hsec_pkg::OP_DECODE,
                     (word ^ (64'd1 << ($urandom_range(n, 1) - 1))) | junk);
        else
            add_item(hsec_pkg::OP_DECODE, {$urandom, $urandom});
    endtask

    // Wait until nothing is queued, offered or outstanding
    task automatic drain_block();
        while (pending_items.size() != 0 || in_ch.valid || expected_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_length(logic [hsec_pkg::KLEN_W-1:0] v);
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        len_setting = v;
        length_writes++;
        @(posedge clk);
    endtask

    // Sender and receiver, both driven on the falling edge
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!in_ch.valid || in_taken)
            begin
                if (pending_items.size() != 0 && !send_hold &&
                    $urandom_range(99) >= send_idle_pct)
                begin
                    in_ch.valid   <= 1'b1;
                    in_ch.opcode  <= pending_items[0].op;
                    in_ch.word_in <= pending_items[0].word;
                    pending_items.delete(0);
                end
                else
                    in_ch.valid <= 1'b0;
            end
            out_ch.ready <= !recv_hold && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Long receiver hold-off, counted here
    always
    begin
        @(hold_off_ev);
        @(negedge clk);
        recv_hold <= 1'b1;
        repeat (LONG_HOLD) @(negedge clk);
        recv_hold <= 1'b0;
    end

    // Result check first, then prediction for the item taken at this edge
    always @(posedge clk)
    begin
        code_result_t got;
        code_result_t want;
        if (!rst_n)
            in_taken <= 1'b0;
        else
        begin
            if (out_ch.valid === 1'b1 && out_ch.ready)
            begin
                got.codeword = out_ch.codeword_out;
                got.data     = out_ch.data_out;
                got.syndrome = out_ch.syndrome;
                got.status   = hsec_pkg::status_t'(out_ch.status);
                if (expected_results.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT)
                        $display("%0t: unexpected item: cw %h data %h syn %0d st %0d",
                                 $realtime, got.codeword, got.data, got.syndrome,
                                 got.status);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got.codeword !== want.codeword || got.data !== want.data ||
                        got.syndrome !== want.syndrome || got.status !== want.status)
                    begin
                        fail_count++;
                        if (fail_count <= REPORT_LIMIT)
                        begin
                            $display("%0t: mismatch, expected cw %h data %h syn %0d st %0d",
                                     $realtime, want.codeword, want.data, want.syndrome,
                                     want.status);
                            $display("%0t:           actual   cw %h data %h syn %0d st %0d",
                                     $realtime, got.codeword, got.data, got.syndrome,
                                     got.status);
                        end
                    end
                end
            end
            if (in_ch.valid && in_ch.ready)
            begin
                want = hamming_predict(len_setting, hsec_pkg::opcode_t'(in_ch.opcode),
                                       in_ch.word_in);
                expected_results.push_back(want);
                if (in_ch.opcode == hsec_pkg::OP_ENCODE)
                    encode_count++;
                else
                begin
                    decode_count++;
                    if (want.status == hsec_pkg::ST_CORRECTED)
                        corrected_count++;
                    if (want.status == hsec_pkg::ST_OUT_OF_RANGE)
                        beyond_count++;
                end
            end
            in_taken <= in_ch.valid && in_ch.ready;
        end
    end

    // Stimulus and end of run
    initial
    begin
        int phase_len [8];
        logic [hsec_pkg::CW_W-1:0] ones;
        logic [hsec_pkg::CW_W-1:0] cw;

        phase_len     = '{1, 57, 4, 26, 11, 33, 63, 0};
        ones          = '1;
        rst_n         = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = '0;
        in_ch.valid   = 1'b0;
        in_ch.opcode  = hsec_pkg::OP_ENCODE;
        in_ch.word_in = '0;
        out_ch.ready  = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset length (57 data bits, 63-bit codeword)
        cw = valid_codeword(ones);
        add_item(hsec_pkg::OP_ENCODE, '0);
        add_item(hsec_pkg::OP_ENCODE, ones);
        add_item(hsec_pkg::OP_ENCODE, 64'd1);
        add_item(hsec_pkg::OP_ENCODE, 64'd1 << 56);
        add_item(hsec_pkg::OP_DECODE, cw);
        add_item(hsec_pkg::OP_DECODE, '0);
        add_item(hsec_pkg::OP_DECODE, ones);
        add_item(hsec_pkg::OP_DECODE, cw ^ 64'd1);
        add_item(hsec_pkg::OP_DECODE, cw ^ (64'd1 << 62));
        add_item(hsec_pkg::OP_DECODE, cw ^ (64'd1 << 31));
        drain_block();

        // 9-bit codeword: syndromes can point past the end
        write_length(6'd5);
        cw = valid_codeword(64'h1f);
        add_item(hsec_pkg::OP_ENCODE, 64'h1f);
        add_item(hsec_pkg::OP_ENCODE, ones);
        add_item(hsec_pkg::OP_DECODE, (64'd1 << 5) | (64'd1 << 8));
        add_item(hsec_pkg::OP_DECODE, cw ^ (64'd1 << 8));
        add_item(hsec_pkg::OP_DECODE, ones);
        drain_block();

        // zero length acts as one data bit
        write_length(6'd0);
        cw = valid_codeword(64'd1);
        add_item(hsec_pkg::OP_ENCODE, 64'd1);
        add_item(hsec_pkg::OP_ENCODE, ones);
        add_item(hsec_pkg::OP_DECODE, cw ^ 64'd2);
        add_item(hsec_pkg::OP_DECODE, 64'h7);
        drain_block();

        // lengths above the maximum act as the maximum
        write_length(6'd63);
        cw = valid_codeword({$urandom, $urandom});
        add_item(hsec_pkg::OP_ENCODE, ones);
        add_item(hsec_pkg::OP_DECODE, cw ^ (64'd1 << 16));
        add_item(hsec_pkg::OP_DECODE, '0);
        drain_block();

        // Random phases: idle modes none / sender / receiver / both
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            if (ph < 8)
                write_length(hsec_pkg::KLEN_W'(phase_len[ph]));
            else
                write_length(hsec_pkg::KLEN_W'($urandom_range(63)));
            case (ph % 4)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 75; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 75; end
                default: begin send_idle_pct = 38; recv_stall_pct = 38; end
            endcase
            for (int i = 0; i < PHASE_ITEMS / 2; i++)
                add_random_item();
            if (ph == 4)
                -> hold_off_ev;
            if (ph == 6)
            begin
                // sender stops until every result is back
                while (pending_items.size() > PHASE_ITEMS / 4)
                    @(posedge clk);
                send_hold = 1'b1;
                while (in_ch.valid || expected_results.size() != 0)
                    @(posedge clk);
                send_hold = 1'b0;
            end
            for (int i = 0; i < PHASE_ITEMS / 2; i++)
                add_random_item();
            drain_block();
        end

        repeat (10) @(posedge clk);
        fail_count += expected_results.size();
        $display("Covered %0d encode and %0d decode items over %0d length settings,",
                 encode_count, decode_count, length_writes);
        $display("with %0d single-bit corrections and %0d syndromes past the codeword.",
                 corrected_count, beyond_count);
        if (fail_count == 0)
            $display("hamming_sec_encode_decode_unit test passed");
        else
            $display("hamming_sec_encode_decode_unit test failed");
        $finish;
    end

    // Watchdog
    initial
    begin
        #2_000_000;
        $display("hamming_sec_encode_decode_unit test failed");
        $finish;
    end

endmodule

// File: sim.f
rtl/hsec_pkg.sv
rtl/hsec_if.sv
rtl/hamming_sec_encode_decode_unit.sv
rtl/hsec_checker.sv
test/hamming_sec_encode_decode_unit_tb.sv
